// ----- rtl/pidf_pkg.sv -----
// ----------------------------------------------------------------------------
// pidf_pkg: shared types and constants of the filtered-derivative PID block
// Register indexes, item modes, sequencer states and the product steps that
// the sequencer runs through the shared multiplier.
// ----------------------------------------------------------------------------
package pidf_pkg;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Bits of the multiplier operand consumed per multiplier cycle.
  localparam int DIG_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP      = 3'd0,
    REG_KI_TS   = 3'd1,
    REG_ALPHA   = 3'd2,
    REG_KD_GAIN = 3'd3,
    REG_KB      = 3'd4,
    REG_U_MIN   = 3'd5,
    REG_U_MAX   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ERROR = 2'd0,
    MODE_MEAS  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ISSUE,
    S_WAIT,
    S_LIMIT,
    S_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    OP_ALPHA,
    OP_KD,
    OP_KI,
    OP_KP,
    OP_KB
  } mul_op_t;

endpackage

// ----- rtl/pidf_in_if.sv -----
// ----------------------------------------------------------------------------
// pidf_in_if: sample channel
// Valid/ready channel that carries one controller sample per transfer.
// ----------------------------------------------------------------------------
interface pidf_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [DATA_WIDTH-1:0] error_value;
  logic signed [DATA_WIDTH-1:0] measurement;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] target_output;
  logic                         sample_invalid;

  modport source (
    output valid, mode, error_value, measurement, setpoint, target_output, sample_invalid,
    input  ready
  );

  modport sink (
    input  valid, mode, error_value, measurement, setpoint, target_output, sample_invalid,
    output ready
  );
endinterface

// ----- rtl/pidf_out_if.sv -----
// ----------------------------------------------------------------------------
// pidf_out_if: result channel
// Valid/ready channel that carries one controller output per transfer.
// ----------------------------------------------------------------------------
interface pidf_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] control_output;
  logic                         clamped;

  modport source (
    output valid, control_output, clamped,
    input  ready
  );

  modport sink (
    input  valid, control_output, clamped,
    output ready
  );
endinterface

// ----- rtl/pidf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pidf_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
interface pidf_cfg_if #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
);
  localparam int CW = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1;

  logic                           valid;
  logic                           ready;
  logic [pidf_pkg::CFG_IDX_W-1:0] index;
  logic [CW-1:0]                  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/pidf_cfg.sv -----
// ----------------------------------------------------------------------------
// pidf_cfg: configuration register bank
// Holds the gains and output limits; alpha is limited to 1.0 on write.
// ----------------------------------------------------------------------------
module pidf_cfg #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  pidf_cfg_if.sink                     cfg,
  output logic signed [DATA_WIDTH-1:0] kp,
  output logic signed [DATA_WIDTH-1:0] ki_ts,
  output logic        [FRAC_BITS:0]    alpha,
  output logic signed [DATA_WIDTH-1:0] kd_gain,
  output logic signed [DATA_WIDTH-1:0] kb,
  output logic signed [DATA_WIDTH-1:0] u_min,
  output logic signed [DATA_WIDTH-1:0] u_max
);

  localparam logic [FRAC_BITS:0]    ONE_A  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DATA_WIDTH-1:0] KP_RST = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] DMIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [FRAC_BITS:0]    alpha_wr;
  logic [DATA_WIDTH-1:0] value;

  assign cfg.ready = 1'b1;
  assign value     = cfg.data[DATA_WIDTH-1:0];
  assign alpha_wr  = (cfg.data[FRAC_BITS:0] > ONE_A) ? ONE_A : cfg.data[FRAC_BITS:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      kp      <= KP_RST;
      ki_ts   <= '0;
      alpha   <= ONE_A;
      kd_gain <= '0;
      kb      <= '0;
      u_min   <= DMIN;
      u_max   <= ~DMIN;
    end else if (cfg.valid) begin
      case (pidf_pkg::cfg_reg_t'(cfg.index))
        pidf_pkg::REG_KP:      kp      <= value;
        pidf_pkg::REG_KI_TS:   ki_ts   <= value;
        pidf_pkg::REG_ALPHA:   alpha   <= alpha_wr;
        pidf_pkg::REG_KD_GAIN: kd_gain <= value;
        pidf_pkg::REG_KB:      kb      <= value;
        pidf_pkg::REG_U_MIN:   u_min   <= value;
        pidf_pkg::REG_U_MAX:   u_max   <= value;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pidf_mul.sv -----
// ----------------------------------------------------------------------------
// pidf_mul: shared fixed-point multiplier
// Sign-magnitude multiply, one 16-bit digit of b per cycle, then a rounding
// step: shift right by FRAC_BITS, round half away from zero, saturate.
// ----------------------------------------------------------------------------
module pidf_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1):0] a,
  input  logic signed [((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1):0] b,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int MW    = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1;
  localparam int DIG   = pidf_pkg::DIG_W;
  localparam int NCH   = (MW + DIG - 1) / DIG;
  localparam int BW    = NCH * DIG;
  localparam int PW    = MW + BW;
  localparam int RW    = PW + 1 - FRAC_BITS;
  localparam int CNT_W = $clog2(NCH + 1);

  localparam logic [PW:0]   RND   = {{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [RW-1:0] LIM_P = {{(RW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [RW-1:0] LIM_N = LIM_P + RW'(1);

  logic [MW-1:0]     a_mag;
  logic [BW-1:0]     b_mag;
  logic              neg;
  logic [PW-1:0]     acc;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic [MW:0]           a_abs, b_abs;
  logic [MW+DIG-1:0]     prod;
  logic [PW:0]           rsum;
  logic [RW-1:0]         shifted, lim, mag;

  assign a_abs   = a[MW] ? -a : a;
  assign b_abs   = b[MW] ? -b : b;
  assign prod    = a_mag * b_mag[BW-1 -: DIG];
  assign rsum    = {1'b0, acc} + RND;
  assign shifted = rsum[PW:FRAC_BITS];
  assign lim     = neg ? LIM_N : LIM_P;
  assign mag     = (shifted > lim) ? lim : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_mag <= a_abs[MW-1:0];
      b_mag <= BW'(b_abs[MW-1:0]);
      neg   <= a[MW] ^ b[MW];
      acc   <= '0;
      cnt   <= CNT_W'(NCH);
    end else if (busy && cnt != '0) begin
      acc   <= (acc << DIG) + PW'(prod);
      b_mag <= b_mag << DIG;
      cnt   <= cnt - CNT_W'(1);
    end else if (busy) begin
      result <= neg ? -mag[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
    end
  end

endmodule

// ----- rtl/pid_filtered_derivative_antiwindup.sv -----
// ----------------------------------------------------------------------------
// pid_filtered_derivative_antiwindup: fixed-point PID with filtered derivative
// Discrete PID controller, back-calculation anti-windup, clamped output.
// ----------------------------------------------------------------------------
// Each sample transfer yields exactly one result transfer. The block works on
// one sample at a time: a small sequencer drives every product through one
// shared multiplier (pidf_mul), which handles 16 bits of its second operand
// per cycle. An error step or a measurement step needs five products
// (alpha*d, kd_gain*delta, ki_ts*e, kp*e, kb*(u_sat-u_unsat)); a bumpless
// init needs one product, and a clear, or a sample flagged invalid, needs
// none. The sample channel is ready only while the sequencer is idle, but a
// finished result waits in its own output register, so the next sample is
// taken while that result is still pending. Configuration writes are always
// accepted and must only be issued while no sample is in flight.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_antiwindup #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  pidf_in_if.sink    sample,
  pidf_out_if.source result,
  pidf_cfg_if.sink   cfg
);

  localparam int DW = DATA_WIDTH;
  localparam int MW = (DW > FRAC_BITS + 1) ? DW : FRAC_BITS + 1;
  // Three guard bits hold any sum of up to four data-width terms exactly.
  localparam int SW = DW + 3;

  localparam logic signed [SW-1:0] DMAX_X = {4'b0000, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] DMIN_X = ~DMAX_X;

  function automatic logic signed [SW-1:0] sx(input logic signed [DW-1:0] v);
    sx = {{(SW-DW){v[DW-1]}}, v};
  endfunction

  // Saturate a wide intermediate into the data width.
  function automatic logic signed [DW-1:0] sat(input logic signed [SW-1:0] x);
    if (x > DMAX_X) begin
      sat = DMAX_X[DW-1:0];
    end else if (x < DMIN_X) begin
      sat = DMIN_X[DW-1:0];
    end else begin
      sat = x[DW-1:0];
    end
  endfunction

  // Configuration registers.
  logic signed [DW-1:0]  kp, ki_ts, kd_gain, kb, u_min, u_max;
  logic        [FRAC_BITS:0] alpha;

  // Controller state.
  logic signed [DW-1:0] integral_sum, derivative_term, last_error;
  logic signed [DW-1:0] last_measurement, last_output;

  // Sequencer.
  pidf_pkg::seq_state_t state, state_next;
  pidf_pkg::mul_op_t    op;

  // Latched sample.
  pidf_pkg::mode_t      mode;
  logic signed [DW-1:0] ev, y, r, tgt;
  logic                 invalid;

  // Working registers of one step.
  logic signed [DW-1:0] e_val, delta, acc_d, dnew, kiu, usat, bdiff;
  logic signed [SW-1:0] unsat;
  logic                 clamp_r;
  logic signed [DW-1:0] res_val;
  logic                 res_clamped;

  // Output register.
  logic                 out_valid;
  logic signed [DW-1:0] out_data;
  logic                 out_clamped;

  // Shared multiplier.
  logic                 mul_start, mul_done;
  logic signed [MW:0]   mul_a, mul_b;
  logic signed [DW-1:0] mul_res;

  // Combinational datapath terms.
  logic signed [SW-1:0] diff_e, diff_y, e_meas, usat_x, p_x;
  logic                 take;

  pidf_cfg #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .kp     (kp),
    .ki_ts  (ki_ts),
    .alpha  (alpha),
    .kd_gain(kd_gain),
    .kb     (kb),
    .u_min  (u_min),
    .u_max  (u_max)
  );

  pidf_mul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .result(mul_res)
  );

  assign result.valid          = out_valid;
  assign result.control_output = out_data;
  assign result.clamped        = out_clamped;

  assign take   = sample.valid && sample.ready;
  assign diff_e = sx(ev) - sx(last_error);
  assign diff_y = sx(y) - sx(last_measurement);
  assign e_meas = sx(r) - sx(y);
  assign p_x    = sx(mul_res);

  // Output limiting: min against u_max first, then max against u_min, so that
  // crossed limits always give u_min.
  always_comb begin
    usat_x = (unsat < sx(u_max)) ? unsat : sx(u_max);
    if (usat_x < sx(u_min)) begin
      usat_x = sx(u_min);
    end
  end

  // Operand selection for the product of the current step. Alpha is an
  // unsigned Q1.FRAC_BITS value and is zero-extended.
  always_comb begin
    unique case (op)
      pidf_pkg::OP_ALPHA: begin
        mul_a = {{(MW-FRAC_BITS){1'b0}}, alpha};
        mul_b = {{(MW+1-DW){derivative_term[DW-1]}}, derivative_term};
      end
      pidf_pkg::OP_KD: begin
        mul_a = {{(MW+1-DW){kd_gain[DW-1]}}, kd_gain};
        mul_b = {{(MW+1-DW){delta[DW-1]}}, delta};
      end
      pidf_pkg::OP_KI: begin
        mul_a = {{(MW+1-DW){ki_ts[DW-1]}}, ki_ts};
        mul_b = {{(MW+1-DW){e_val[DW-1]}}, e_val};
      end
      pidf_pkg::OP_KP: begin
        mul_a = {{(MW+1-DW){kp[DW-1]}}, kp};
        mul_b = {{(MW+1-DW){e_val[DW-1]}}, e_val};
      end
      pidf_pkg::OP_KB: begin
        mul_a = {{(MW+1-DW){kb[DW-1]}}, kb};
        mul_b = {{(MW+1-DW){bdiff[DW-1]}}, bdiff};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next   = state;
    mul_start    = 1'b0;
    sample.ready = (state == pidf_pkg::S_IDLE);
    unique case (state)
      pidf_pkg::S_IDLE: begin
        if (sample.valid) begin
          state_next = pidf_pkg::S_PREP;
        end
      end
      pidf_pkg::S_PREP: begin
        unique case (mode)
          pidf_pkg::MODE_CLEAR: state_next = pidf_pkg::S_OUT;
          pidf_pkg::MODE_INIT:  state_next = pidf_pkg::S_ISSUE;
          pidf_pkg::MODE_ERROR,
          pidf_pkg::MODE_MEAS:  state_next = invalid ? pidf_pkg::S_OUT : pidf_pkg::S_ISSUE;
          default:              state_next = pidf_pkg::S_OUT;
        endcase
      end
      pidf_pkg::S_ISSUE: begin
        mul_start  = 1'b1;
        state_next = pidf_pkg::S_WAIT;
      end
      pidf_pkg::S_WAIT: begin
        if (mul_done) begin
          if (op == pidf_pkg::OP_KB) begin
            state_next = pidf_pkg::S_OUT;
          end else if (op == pidf_pkg::OP_KP) begin
            state_next = (mode == pidf_pkg::MODE_INIT) ? pidf_pkg::S_OUT : pidf_pkg::S_LIMIT;
          end else begin
            state_next = pidf_pkg::S_ISSUE;
          end
        end
      end
      pidf_pkg::S_LIMIT: begin
        state_next = pidf_pkg::S_ISSUE;
      end
      pidf_pkg::S_OUT: begin
        if (!out_valid || result.ready) begin
          state_next = pidf_pkg::S_IDLE;
        end
      end
      default: state_next = pidf_pkg::S_IDLE;
    endcase
  end

  // Control state and controller state, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= pidf_pkg::S_IDLE;
      out_valid        <= 1'b0;
      integral_sum     <= '0;
      derivative_term  <= '0;
      last_error       <= '0;
      last_measurement <= '0;
      last_output      <= '0;
    end else begin
      state <= state_next;
      if (state == pidf_pkg::S_OUT && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (state == pidf_pkg::S_PREP && mode == pidf_pkg::MODE_CLEAR) begin
        integral_sum     <= '0;
        derivative_term  <= '0;
        last_error       <= '0;
        last_measurement <= '0;
        last_output      <= '0;
      end
      if (state == pidf_pkg::S_WAIT && mul_done) begin
        if (op == pidf_pkg::OP_KP && mode == pidf_pkg::MODE_INIT) begin
          // Bumpless init: the integral absorbs the proportional part so the
          // next step starts from the requested output.
          integral_sum    <= sat(sx(tgt) - p_x);
          derivative_term <= '0;
          last_error      <= ev;
          last_output     <= tgt;
        end else if (op == pidf_pkg::OP_KB) begin
          // Back-calculation: the integral is pulled back by kb times the
          // amount the output limiter cut off.
          integral_sum    <= sat(sx(integral_sum) + sx(kiu) + p_x);
          derivative_term <= dnew;
          last_error      <= e_val;
          last_output     <= usat;
          if (mode == pidf_pkg::MODE_MEAS) begin
            last_measurement <= y;
          end
        end
      end
    end
  end

  // Sample latch and working registers; no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      mode    <= pidf_pkg::mode_t'(sample.mode);
      ev      <= sample.error_value;
      y       <= sample.measurement;
      r       <= sample.setpoint;
      tgt     <= sample.target_output;
      invalid <= sample.sample_invalid;
    end

    unique case (state)
      pidf_pkg::S_PREP: begin
        res_clamped <= 1'b0;
        unique case (mode)
          pidf_pkg::MODE_CLEAR: begin
            res_val <= '0;
          end
          pidf_pkg::MODE_INIT: begin
            e_val <= ev;
            op    <= pidf_pkg::OP_KP;
          end
          pidf_pkg::MODE_ERROR: begin
            res_val <= last_output;
            e_val   <= ev;
            delta   <= sat(diff_e);
            op      <= pidf_pkg::OP_ALPHA;
          end
          pidf_pkg::MODE_MEAS: begin
            // Derivative on measurement: the filter sees the change in y.
            res_val <= last_output;
            e_val   <= sat(e_meas);
            delta   <= sat(diff_y);
            op      <= pidf_pkg::OP_ALPHA;
          end
          default: ;
        endcase
      end
      pidf_pkg::S_WAIT: begin
        if (mul_done) begin
          unique case (op)
            pidf_pkg::OP_ALPHA: begin
              acc_d <= mul_res;
              op    <= pidf_pkg::OP_KD;
            end
            pidf_pkg::OP_KD: begin
              if (mode == pidf_pkg::MODE_MEAS) begin
                dnew <= sat(sx(acc_d) - p_x);
              end else begin
                dnew <= sat(sx(acc_d) + p_x);
              end
              op <= pidf_pkg::OP_KI;
            end
            pidf_pkg::OP_KI: begin
              kiu <= mul_res;
              op  <= pidf_pkg::OP_KP;
            end
            pidf_pkg::OP_KP: begin
              // The unsaturated output is kept exact over all four terms.
              unsat   <= p_x + sx(integral_sum) + sx(kiu) + sx(dnew);
              res_val <= tgt;
            end
            pidf_pkg::OP_KB: begin
              res_val     <= usat;
              res_clamped <= clamp_r;
            end
            default: ;
          endcase
        end
      end
      pidf_pkg::S_LIMIT: begin
        usat    <= usat_x[DW-1:0];
        clamp_r <= (usat_x != unsat);
        bdiff   <= sat(usat_x - unsat);
        op      <= pidf_pkg::OP_KB;
      end
      pidf_pkg::S_OUT: begin
        if (!out_valid || result.ready) begin
          out_data    <= res_val;
          out_clamped <= res_clamped;
        end
      end
      default: ;
    endcase
  end

endmodule
